### hw/rtl/cheb_pkg.sv
// Shared types, constants and helpers for the Chebyshev series evaluator.
// Holds the Q8.24 format, the saturation helper, and the transaction and
// register codes. No dependencies.
`default_nettype none

package cheb_pkg;

    localparam int Q_FRAC  = 24;
    localparam int DATA_W  = 32;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int RND_W   = PROD_W - Q_FRAC;
    localparam int ACC_W   = RND_W + 4;
    localparam int TC_W    = 9;
    localparam int CIDX_W  = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'sd1 <<< (Q_FRAC - 1));
    localparam logic signed [ACC_W-1:0]  ACC_MAX  = ACC_W'(32'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0]  ACC_MIN  = ACC_W'(signed'(32'h8000_0000));

    localparam logic [TC_W-1:0]          TERM_COUNT_RST = 9'd1;
    localparam logic signed [DATA_W-1:0] MAP_SCALE_RST  = 32'sd33554432;
    localparam logic signed [DATA_W-1:0] MAP_OFFSET_RST = 32'sd16777216;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_EVAL = 1'b1
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TERM_COUNT = 2'd0,
        CFG_MAP_SCALE  = 2'd1,
        CFG_MAP_OFFSET = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic                     flag;
        logic signed [DATA_W-1:0] value;
    } t_sat;

    function automatic t_sat sat32(input logic signed [ACC_W-1:0] v);
        t_sat r;
        if (v > ACC_MAX) begin
            r.flag  = 1'b1;
            r.value = DATA_W'(ACC_MAX);
        end else if (v < ACC_MIN) begin
            r.flag  = 1'b1;
            r.value = DATA_W'(ACC_MIN);
        end else begin
            r.flag  = 1'b0;
            r.value = signed'(v[DATA_W-1:0]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/chebyshev_series_evaluator.sv
// Top level of the Chebyshev series evaluator (Clenshaw recurrence, Q8.24).
// Coefficient memory, shared 32x32 multiplier and recurrence sequencer.
// Depends on cheb_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall): a load transaction writes one
//   coefficient and leaves the block idle; an evaluate transaction maps the
//   point, runs the backward recurrence and yields one result.
//   Output channel (o_valid / i_stall): one result per evaluate.
//   Configuration: i_cfg_we writes term_count, map_scale or map_offset by
//   index; write only while the block is idle.
//   Sequence: with N = term_count limited to [1, MAX_TERMS], an accepted
//   evaluate first maps the point; the recurrence then gives each of the N
//   coefficients a step through the registered multiplier together with the
//   coefficient memory read, and a step for the add and saturate. One evaluate
//   is in flight at a time; o_stall is high while it runs, so the next
//   transaction is accepted only after its result enters the output register.
//   Stall: a pending result waits in the output register while the next
//   transaction is accepted; a later result holds in the final step until
//   the output register is free.
//   Reset: synchronous, active low; clears control and restores register
//   defaults. Coefficient memory contents are undefined until loaded.
`default_nettype none

module chebyshev_series_evaluator #(
    parameter int MAX_TERMS = 256
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic                                 i_action,
    input  wire logic [cheb_pkg::CIDX_W-1:0]          i_coef_index,
    input  wire logic signed [cheb_pkg::DATA_W-1:0]   i_coef_value,
    input  wire logic signed [cheb_pkg::DATA_W-1:0]   i_point,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed [cheb_pkg::DATA_W-1:0]        o_series_value,
    output logic                                      o_saturated,
    input  wire logic                                 i_cfg_we,
    input  wire logic [cheb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [cheb_pkg::DATA_W-1:0]          i_cfg_data
);
    import cheb_pkg::*;

    localparam int AW = $clog2(MAX_TERMS);
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int IW = (CW > TC_W) ? CW : TC_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_MUL,
        ST_ADD,
        ST_FMUL,
        ST_FADD
    } t_state;

    t_state                    r_state, n_state;
    logic [TC_W-1:0]           r_term_count;
    logic signed [DATA_W-1:0]  r_map_scale;
    logic signed [DATA_W-1:0]  r_map_offset;
    logic [AW-1:0]             r_j, n_j;
    logic signed [DATA_W-1:0]  r_z, n_z;
    logic signed [DATA_W-1:0]  r_d, n_d;
    logic signed [DATA_W-1:0]  r_d2, n_d2;
    logic                      r_flag, n_flag;
    logic signed [PROD_W-1:0]  r_prod;
    logic [DATA_W-1:0]         r_rdata;
    logic                      r_o_valid, n_o_valid;
    logic signed [DATA_W-1:0]  r_o_value, n_o_value;
    logic                      r_o_sat, n_o_sat;

    logic [DATA_W-1:0]         r_coef_mem [MAX_TERMS];

    logic                      in_acc;
    logic                      eval_acc;
    logic                      load_acc;
    logic [IW-1:0]             idx_ext;
    logic [IW-1:0]             tc_ext;
    logic [IW-1:0]             n_terms;
    logic                      mul_en;
    logic signed [DATA_W-1:0]  mul_a, mul_b;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic signed [PROD_W-1:0]  prod_rnd;
    logic signed [RND_W-1:0]   rnd;
    logic signed [DATA_W-1:0]  coef;
    logic                      out_free;
    t_sat                      sat_map, sat_step, sat_fin;

    assign o_stall        = (r_state != ST_IDLE) || !i_rst_n;
    assign o_valid        = r_o_valid;
    assign o_series_value = r_o_value;
    assign o_saturated    = r_o_sat;

    assign in_acc   = i_valid && !o_stall;
    assign eval_acc = in_acc && (i_action == ACT_EVAL);
    assign load_acc = in_acc && (i_action == ACT_LOAD);
    assign idx_ext  = IW'(i_coef_index);
    assign tc_ext   = IW'(r_term_count);
    assign n_terms  = (tc_ext > IW'(MAX_TERMS)) ? IW'(MAX_TERMS) : tc_ext;
    assign out_free = !r_o_valid || !i_stall;

    assign mul_en  = eval_acc || (r_state == ST_MUL) || (r_state == ST_FMUL);
    assign mul_a   = (r_state == ST_IDLE) ? r_map_scale : r_z;
    assign mul_b   = (r_state == ST_IDLE) ? i_point : r_d;
    assign rd_en   = (r_state == ST_MUL) || (r_state == ST_FMUL);
    assign rd_addr = (r_state == ST_FMUL) ? '0 : r_j;

    assign prod_rnd = r_prod + RND_HALF;
    assign rnd      = signed'(prod_rnd[PROD_W-1:Q_FRAC]);
    assign coef     = signed'(r_rdata);

    assign sat_map  = sat32(ACC_W'(rnd) - ACC_W'(r_map_offset));
    assign sat_step = sat32(ACC_W'(rnd) + ACC_W'(rnd) - ACC_W'(r_d2) + ACC_W'(coef));
    assign sat_fin  = sat32(ACC_W'(rnd) - ACC_W'(r_d2) + ACC_W'(coef >>> 1));

    always_ff @(posedge i_clk) begin
        if (load_acc && (idx_ext < IW'(MAX_TERMS))) begin
            r_coef_mem[idx_ext[AW-1:0]] <= i_coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_coef_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_j       = r_j;
        n_z       = r_z;
        n_d       = r_d;
        n_d2      = r_d2;
        n_flag    = r_flag;
        n_o_valid = r_o_valid && i_stall;
        n_o_value = r_o_value;
        n_o_sat   = r_o_sat;
        unique case (r_state)
            ST_IDLE: begin
                if (eval_acc) begin
                    n_flag  = 1'b0;
                    n_state = ST_MAP;
                end
            end
            ST_MAP: begin
                n_z    = sat_map.value;
                n_flag = sat_map.flag;
                n_d    = '0;
                n_d2   = '0;
                if (n_terms > IW'(1)) begin
                    n_j     = AW'(n_terms - IW'(1));
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_FMUL;
                end
            end
            ST_MUL: begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                n_d    = sat_step.value;
                n_d2   = r_d;
                n_flag = r_flag || sat_step.flag;
                if (r_j == AW'(1)) begin
                    n_state = ST_FMUL;
                end else begin
                    n_j     = r_j - AW'(1);
                    n_state = ST_MUL;
                end
            end
            ST_FMUL: begin
                n_state = ST_FADD;
            end
            ST_FADD: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_value = sat_fin.value;
                    n_o_sat   = r_flag || sat_fin.flag;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_o_valid    <= 1'b0;
            r_term_count <= TERM_COUNT_RST;
            r_map_scale  <= MAP_SCALE_RST;
            r_map_offset <= MAP_OFFSET_RST;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TERM_COUNT: r_term_count <= i_cfg_data[TC_W-1:0];
                    CFG_MAP_SCALE:  r_map_scale  <= signed'(i_cfg_data);
                    CFG_MAP_OFFSET: r_map_offset <= signed'(i_cfg_data);
                    default: begin
                    end
                endcase
            end
        end
        r_j       <= n_j;
        r_z       <= n_z;
        r_d       <= n_d;
        r_d2      <= n_d2;
        r_flag    <= n_flag;
        r_o_value <= n_o_value;
        r_o_sat   <= n_o_sat;
    end

endmodule

`default_nettype wire

### hw/rtl/cheb_chk.sv
// Port-level checker for the Chebyshev series evaluator, bound to the top.
// Watches both channels over time. Depends on cheb_pkg.
`default_nettype none

module cheb_chk (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_valid,
    input wire logic                               o_stall,
    input wire logic                               i_action,
    input wire logic                               o_valid,
    input wire logic                               i_stall,
    input wire logic signed [cheb_pkg::DATA_W-1:0] o_series_value,
    input wire logic                               o_saturated
);
    import cheb_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_series_value) && $stable(o_saturated))
        else $error("stalled result changed");

    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_action == ACT_EVAL) |=> o_stall)
        else $error("evaluate transaction did not start work");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_action == ACT_LOAD) |=> !o_stall)
        else $error("load transaction left the block busy");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without work in progress");

endmodule

bind chebyshev_series_evaluator cheb_chk u_cheb_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_action       (i_action),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_series_value (o_series_value),
    .o_saturated    (o_saturated)
);

`default_nettype wire

### verif/chebyshev_series_evaluator_tb.sv
// Self-checking testbench for chebyshev_series_evaluator: Clenshaw series
// evaluation in Q8.24 with saturation. Depends on cheb_pkg and the top
// level RTL; expected results come from a predictor kept in a scoreboard.
`timescale 1ns / 1ps

module chebyshev_series_evaluator_tb;

    localparam int STORE_DEPTH = 256;
    localparam int NUM_PHASES = 14;
    localparam int RX_HOLD = 1500;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic [31:0] Q_ONE = 32'h0100_0000;
    localparam logic [31:0] Q_HALF = 32'h0080_0000;
    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;
    localparam logic [cheb_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic signed [31:0] value;
        logic               sat;
    } series_out_t;

    class series_scoreboard;
        logic [8:0]  terms;
        int          scale;
        int          offset;
        int          coefs[STORE_DEPTH];
        series_out_t pending[$];
        int          errors;
        int          checked;
        int          sat_count;
        int          loads;

        function new();
            terms = cheb_pkg::TERM_COUNT_RST;
            scale = cheb_pkg::MAP_SCALE_RST;
            offset = cheb_pkg::MAP_OFFSET_RST;
            errors = 0;
            checked = 0;
            sat_count = 0;
            loads = 0;
            foreach (coefs[k]) coefs[k] = 0;
        endfunction

        function void write_reg(logic [cheb_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                cheb_pkg::CFG_TERM_COUNT: terms = data[8:0];
                cheb_pkg::CFG_MAP_SCALE:  scale = data;
                cheb_pkg::CFG_MAP_OFFSET: offset = data;
                default: ;
            endcase
        endfunction

        function longint fx_product(int a, int b);
            return (longint'(a) * longint'(b) + (longint'(1) <<< 23)) >>> 24;
        endfunction

        function int clamp(longint v, inout bit hit);
            if (v > 64'sd2147483647) begin
                hit = 1'b1;
                return 32'h7FFF_FFFF;
            end
            if (v < -64'sd2147483648) begin
                hit = 1'b1;
                return 32'h8000_0000;
            end
            return int'(v);
        endfunction

        function series_out_t series_at(int pt);
            series_out_t r;
            bit          hit;
            int          n;
            int          j;
            int          z;
            int          d;
            int          d2;
            int          prev;
            longint      acc;
            hit = 1'b0;
            d = 0;
            d2 = 0;
            n = (terms == 0) ? 1 : ((terms > STORE_DEPTH) ? STORE_DEPTH : int'(terms));
            z = clamp(fx_product(scale, pt) - longint'(offset), hit);
            for (j = n; j > 1; j--) begin
                prev = d;
                acc = 2 * fx_product(z, d) - longint'(d2) + longint'(coefs[j-1]);
                d = clamp(acc, hit);
                d2 = prev;
            end
            acc = fx_product(z, d) - longint'(d2) + (longint'(coefs[0]) >>> 1);
            r.value = clamp(acc, hit);
            r.sat = hit;
            return r;
        endfunction

        function void note_input(logic act, logic [7:0] idx, logic [31:0] cval,
                                 logic [31:0] pt);
            if (act == cheb_pkg::ACT_LOAD) begin
                coefs[idx] = cval;
                loads++;
            end else begin
                pending.push_back(series_at(pt));
            end
        endfunction

        task report(string what);
            errors++;
            if (errors <= 100) $display("mismatch: %s", what);
        endtask

        task check_result(logic signed [31:0] got_value, logic got_sat);
            series_out_t want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result value=%h sat=%b", got_value, got_sat));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.sat) sat_count++;
            if (got_value !== want.value)
                report($sformatf("result %0d: series_value %h, want %h",
                                 checked, got_value, want.value));
            if (got_sat !== want.sat)
                report($sformatf("result %0d: saturated %b, want %b",
                                 checked, got_sat, want.sat));
        endtask

        task close_out();
            series_out_t want;
            while (pending.size() != 0) begin
                want = pending.pop_front();
                report($sformatf("missing result, want value=%h sat=%b",
                                 want.value, want.sat));
            end
        endtask
    endclass

    logic                                    i_clk = 1'b0;
    logic                                    i_rst_n = 1'b0;
    logic                                    i_valid = 1'b0;
    logic                                    o_stall;
    logic                                    i_action = 1'b0;
    logic [cheb_pkg::CIDX_W-1:0]             i_coef_index = '0;
    logic signed [cheb_pkg::DATA_W-1:0]      i_coef_value = '0;
    logic signed [cheb_pkg::DATA_W-1:0]      i_point = '0;
    logic                                    o_valid;
    logic                                    i_stall = 1'b0;
    logic signed [cheb_pkg::DATA_W-1:0]      o_series_value;
    logic                                    o_saturated;
    logic                                    i_cfg_we = 1'b0;
    logic [cheb_pkg::CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [cheb_pkg::DATA_W-1:0]             i_cfg_data = '0;

    series_scoreboard sb;
    bit               written[STORE_DEPTH];
    logic [8:0]       cur_terms = cheb_pkg::TERM_COUNT_RST;
    bit               calm = 1'b0;
    bit               hold_rx = 1'b0;
    longint           cycles = 0;

    chebyshev_series_evaluator #(
        .MAX_TERMS(STORE_DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_coef_index   (i_coef_index),
        .i_coef_value   (i_coef_value),
        .i_point        (i_point),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_series_value (o_series_value),
        .o_saturated    (o_saturated),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending.size());
            $display("chebyshev_series_evaluator_tb: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1 && !i_stall) sb.check_result(o_series_value, o_saturated);
            if (i_cfg_we) sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_valid && o_stall === 1'b0)
                sb.note_input(i_action, i_coef_index, i_coef_value, i_point);
        end
    end

    function automatic int run_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 16);
        return $urandom_range(40, 200);
    endfunction

    function automatic int sender_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    // Receiver: random stall runs, or one long hold-off on request.
    initial begin
        @(negedge i_clk);
        forever begin
            if (hold_rx) begin
                i_stall <= 1'b1;
                repeat (RX_HOLD) @(negedge i_clk);
                hold_rx = 1'b0;
            end else begin
                i_stall <= !calm && ($urandom_range(0, 99) < 35);
                repeat (run_length()) @(negedge i_clk);
            end
        end
    end

    function automatic int eff_terms();
        if (cur_terms == 0) return 1;
        if (cur_terms > STORE_DEPTH) return STORE_DEPTH;
        return int'(cur_terms);
    endfunction

    function automatic int first_unwritten();
        for (int j = 0; j < eff_terms(); j++)
            if (!written[j]) return j;
        return -1;
    endfunction

    function automatic logic [31:0] pick_coef();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            case ($urandom_range(0, 3))
                0: return WORD_MAX;
                1: return WORD_MIN;
                2: return 32'h0;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (r < 20) return $urandom;
        return $urandom_range(0, 2 * Q_ONE) - Q_ONE;
    endfunction

    function automatic logic [31:0] pick_point();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            case ($urandom_range(0, 3))
                0: return WORD_MAX;
                1: return WORD_MIN;
                2: return 32'h0;
                default: return Q_ONE;
            endcase
        end
        if (r < 25) return $urandom;
        return $urandom_range(0, 2 * Q_ONE) - Q_ONE;
    endfunction

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic send(logic act, logic [7:0] idx, logic [31:0] cval, logic [31:0] pt);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action <= act;
        i_coef_index <= idx;
        i_coef_value <= cval;
        i_point <= pt;
        i_valid <= 1'b1;
        if (act == cheb_pkg::ACT_LOAD) written[idx] = 1'b1;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic load(logic [7:0] idx, logic [31:0] cval);
        send(cheb_pkg::ACT_LOAD, idx, cval, $urandom);
    endtask

    task automatic evaluate_at(logic [31:0] pt);
        send(cheb_pkg::ACT_EVAL, 8'($urandom), $urandom, pt);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    // Drain, then let a trailing load or evaluation finish before touching registers.
    task automatic settle();
        drain();
        repeat (2 * eff_terms() + 8) @(negedge i_clk);
    endtask

    task automatic configure(logic [31:0] tc_word, logic [31:0] sc, logic [31:0] off);
        i_cfg_we <= 1'b1;
        i_cfg_index <= cheb_pkg::CFG_TERM_COUNT;
        i_cfg_data <= tc_word;
        @(negedge i_clk);
        i_cfg_index <= cheb_pkg::CFG_MAP_SCALE;
        i_cfg_data <= sc;
        @(negedge i_clk);
        i_cfg_index <= cheb_pkg::CFG_MAP_OFFSET;
        i_cfg_data <= off;
        @(negedge i_clk);
        i_cfg_index <= CFG_SPARE;
        i_cfg_data <= $urandom;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_terms = tc_word[8:0];
    endtask

    task automatic run_directed();
        load(8'd0, Q_ONE);
        evaluate_at(32'h0);
        evaluate_at(WORD_MAX);
        evaluate_at(WORD_MIN);
        load(8'd0, WORD_MAX);
        evaluate_at(Q_HALF);
        load(8'd0, WORD_MIN);
        evaluate_at(Q_HALF);
        load(8'd0, 32'hFFFF_FFFF);
        evaluate_at(Q_HALF);
        load(8'd0, 32'h0000_0003);
        evaluate_at(Q_HALF);
        load(8'd255, WORD_MIN);
        load(8'd255, WORD_MAX);
        load(8'd1, WORD_MAX);
        load(8'd2, WORD_MAX);
        settle();
        configure(32'd3, Q_ONE, 32'h0);
        evaluate_at(Q_ONE);
        evaluate_at(WORD_MIN);
        load(8'd1, 32'h0040_0000);
        load(8'd2, 32'hFF80_0000);
        evaluate_at(Q_HALF);
        evaluate_at(32'hFF00_0000);
    endtask

    task automatic run_phase(int ph);
        logic [31:0] tc_word;
        logic [31:0] sc;
        logic [31:0] off;
        int          count;
        int          k;
        int          gap_idx;
        count = 95;
        tc_word = 32'd4;
        sc = Q_ONE;
        off = 32'h0;
        case (ph)
            0: begin
                sc = 32'h0200_0000;
                off = Q_ONE;
            end
            1: tc_word = 32'd0;
            2: begin
                tc_word = 32'd8;
                sc = WORD_MAX;
                off = WORD_MIN;
            end
            3: begin
                tc_word = 32'd16;
                sc = WORD_MIN;
                off = WORD_MAX;
            end
            4: begin
                tc_word = 32'd256;
                count = 40;
            end
            5: begin
                tc_word = 32'd3;
                sc = 32'h0;
                off = $urandom;
            end
            6: begin
                tc_word = 32'd511;
                sc = Q_HALF;
                off = 32'h0040_0000;
                count = 40;
            end
            7: tc_word = 32'd2;
            8: tc_word = 32'd6;
            default: begin
                tc_word = ($urandom & 32'hFFFF_FE00) | $urandom_range(1, 24);
                sc = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
                off = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
            end
        endcase
        settle();
        configure(tc_word, sc, off);
        calm = (ph == 7);
        if (ph == 8) hold_rx = 1'b1;
        k = 0;
        while (k < count) begin
            if (ph % 3 == 1 && k == count / 2) drain();
            gap_idx = first_unwritten();
            if (gap_idx >= 0) begin
                load(8'(gap_idx), pick_coef());
            end else begin
                k++;
                if ($urandom_range(0, 99) < 50)
                    evaluate_at(pick_point());
                else if ($urandom_range(0, 99) < 70)
                    load(8'($urandom_range(0, eff_terms() - 1)), pick_coef());
                else
                    load(8'($urandom_range(0, STORE_DEPTH - 1)), pick_coef());
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        run_directed();
        for (int ph = 0; ph < NUM_PHASES; ph++) run_phase(ph);
        settle();
        sb.close_out();
        $display("run summary: %0d coefficient loads, %0d evaluations checked",
                 sb.loads, sb.checked);
        $display("run summary: %0d saturated, %0d register settings, %0d cycles",
                 sb.sat_count, NUM_PHASES + 1, cycles);
        if (sb.errors == 0) begin
            $display("chebyshev_series_evaluator_tb: clean");
        end else begin
            $display("chebyshev_series_evaluator_tb: errors");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/cheb_pkg.sv
hw/rtl/chebyshev_series_evaluator.sv
hw/rtl/cheb_chk.sv
verif/chebyshev_series_evaluator_tb.sv
